// ----- hdl/page_frame_free_list_allocator_top_defines.svh -----
// Assertion macros for the page-frame allocator.
`ifndef PAGE_FRAME_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH
`define PAGE_FRAME_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH

// Concurrent check on the rising clock, held off during reset
`define PFA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also holds while reset is active
`define PFA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/pfa_pkg.sv -----
// Shared constants and types of the page-frame allocator.
package pfa_pkg;
  localparam int NUM_FRAMES  = 1024;
  localparam int IDX_W       = $clog2(NUM_FRAMES);
  localparam int LINK_W      = IDX_W + 1;
  localparam int FRAME_BYTES = 32'h1000;

  localparam logic [LINK_W-1:0] NIL = LINK_W'(NUM_FRAMES);

  typedef logic [LINK_W-1:0] link_t;
  typedef logic [IDX_W-1:0]  idx_t;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_RUN  = 2'd1,
    ST_BAD_REQ = 2'd2
  } status_e;
endpackage

// ----- hdl/page_frame_free_list_allocator_top.sv -----
// Page-frame allocator top level: free list and used marks in block memories.
// Frames 0..total_frames-1 are handed out by index (address = index * 0x1000).
// A free of a frame out of range, or of a frame whose used mark reads free,
// is rejected; a valid free marks the frame unused, pushes it at the head
// and links the former head, if any, back to it. An allocate is rejected at
// once for count zero, count too long or an empty list; else it walks the
// free list, bound checking each entry's run and reading the used marks of
// its further frames, reads the next link of an entry passed over and
// unlinks each frame of the run taken. The walk and unlink go one memory
// read a cycle through the shared read port of the link and used memories.
// The finishing state waits while the previous result still sits unaccepted
// in the output register. After reset and every total_frames write a
// clearing pass over all 1024 frames rebuilds the list, accepting no item.
// A finished result sits in an output register while the next is accepted.
`include "page_frame_free_list_allocator_top_defines.svh"
module page_frame_free_list_allocator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: total_frames
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // alloc_count[10:0], frame_index[20:11], zeros
  input  logic        s_axis_tuser,   // func
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // status[1:0], first_frame[11:2], zeros
);
  import pfa_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_CHK, S_RUN_W, S_NXT_W, S_UL_W, S_FR_W, S_FR2, S_DONE
  } state_e;

  state_e           state_q, state_d;
  logic [LINK_W-1:0] total_q, total_d;
  link_t            head_q, head_d;
  link_t            pos_q, pos_d;
  logic [LINK_W-1:0] k_q, k_d;
  logic [LINK_W-1:0] cnt_q, cnt_d;
  idx_t             fidx_q, fidx_d;
  status_e          res_st_q, res_st_d;
  idx_t             res_first_q, res_first_d;
  logic             out_valid_q;
  status_e          out_st_q;
  idx_t             out_first_q;

  // memories
  link_t next_mem [NUM_FRAMES];
  link_t prev_mem [NUM_FRAMES];
  logic  used_mem [NUM_FRAMES];

  idx_t  rd_addr, rd_addr_q;
  link_t next_raw_q, prev_raw_q;
  logic  used_raw_q;
  link_t next_rd, prev_rd;
  logic  used_rd;

  logic  next_we, prev_we, used_we;
  idx_t  next_wa, prev_wa, used_wa;
  link_t next_wd, prev_wd;
  logic  used_wd;

  // last-cycle writes, forwarded over the read that overlapped them
  logic  fn_v_q, fp_v_q, fu_v_q;
  idx_t  fn_a_q, fp_a_q, fu_a_q;
  link_t fn_d_q, fp_d_q;
  logic  fu_d_q;

  logic [LINK_W-1:0] in_cnt;
  idx_t              in_fidx;
  logic [LINK_W-1:0] cfg_sat;
  logic [LINK_W:0]   run_end;
  logic [LINK_W-1:0] k_inc;
  idx_t              run_addr;
  idx_t              clr_idx;

  assign in_cnt  = s_axis_tdata[10:0];
  assign in_fidx = s_axis_tdata[20:11];
  assign k_inc   = k_q + 1'b1;
  assign run_end = {1'b0, pos_q} + {1'b0, cnt_q};
  assign run_addr = IDX_W'(pos_q + k_q);
  assign clr_idx  = k_q[IDX_W-1:0];

  // saturate written frame count to 1..NUM_FRAMES
  always_comb begin
    if (cfg_wdata_i == '0) begin
      cfg_sat = LINK_W'(1);
    end else if ({1'b0, cfg_wdata_i} > (LINK_W+1)'(NUM_FRAMES)) begin
      cfg_sat = LINK_W'(NUM_FRAMES);
    end else begin
      cfg_sat = LINK_W'(cfg_wdata_i);
    end
  end

  // forwarded read data
  assign next_rd = (fn_v_q && fn_a_q == rd_addr_q) ? fn_d_q : next_raw_q;
  assign prev_rd = (fp_v_q && fp_a_q == rd_addr_q) ? fp_d_q : prev_raw_q;
  assign used_rd = (fu_v_q && fu_a_q == rd_addr_q) ? fu_d_q : used_raw_q;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_first_q, out_st_q};

  // sequencer
  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    head_d      = head_q;
    pos_d       = pos_q;
    k_d         = k_q;
    cnt_d       = cnt_q;
    fidx_d      = fidx_q;
    res_st_d    = res_st_q;
    res_first_d = res_first_q;
    rd_addr     = '0;
    next_we = 1'b0; next_wa = '0; next_wd = NIL;
    prev_we = 1'b0; prev_wa = '0; prev_wd = NIL;
    used_we = 1'b0; used_wa = '0; used_wd = 1'b0;

    case (state_q)
      S_CLR: begin
        next_we = 1'b1; prev_we = 1'b1; used_we = 1'b1;
        next_wa = clr_idx; prev_wa = clr_idx; used_wa = clr_idx;
        used_wd = 1'b0;
        next_wd = (k_q < total_q && k_q != '0) ? link_t'(k_q - 1'b1) : NIL;
        prev_wd = (k_inc < total_q) ? link_t'(k_inc) : NIL;
        k_d = k_inc;
        if (k_q == LINK_W'(NUM_FRAMES - 1)) begin
          head_d  = total_q - 1'b1;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cnt_d  = in_cnt;
          fidx_d = in_fidx;
          res_first_d = '0;
          if (s_axis_tuser == FUNC_FREE) begin
            rd_addr = in_fidx;
            if ({1'b0, in_fidx} >= total_q) begin
              res_st_d = ST_BAD_REQ;
              state_d  = S_DONE;
            end else begin
              state_d = S_FR_W;
            end
          end else if (in_cnt == '0) begin
            res_st_d = ST_BAD_REQ;
            state_d  = S_DONE;
          end else if (in_cnt > total_q || head_q == NIL) begin
            res_st_d = ST_NO_RUN;
            state_d  = S_DONE;
          end else begin
            pos_d   = head_q;
            k_d     = LINK_W'(1);
            state_d = S_CHK;
          end
        end
      end
      // candidate start: bound check, then scan the rest of its run
      S_CHK: begin
        if (run_end > {1'b0, total_q}) begin
          rd_addr = pos_q[IDX_W-1:0];
          state_d = S_NXT_W;
        end else if (k_q == cnt_q) begin
          k_d     = '0;
          rd_addr = pos_q[IDX_W-1:0];
          state_d = S_UL_W;
        end else begin
          rd_addr = run_addr;
          state_d = S_RUN_W;
        end
      end
      S_RUN_W: begin
        if (used_rd) begin
          rd_addr = pos_q[IDX_W-1:0];
          state_d = S_NXT_W;
        end else if (k_inc == cnt_q) begin
          k_d     = '0;
          rd_addr = pos_q[IDX_W-1:0];
          state_d = S_UL_W;
        end else begin
          k_d     = k_inc;
          rd_addr = IDX_W'(pos_q + k_inc);
        end
      end
      S_NXT_W: begin
        pos_d = next_rd;
        k_d   = LINK_W'(1);
        if (next_rd == NIL) begin
          res_st_d = ST_NO_RUN;
          state_d  = S_DONE;
        end else begin
          state_d = S_CHK;
        end
      end
      // unlink frame pos+k: links of it were read last cycle
      S_UL_W: begin
        used_we = 1'b1; used_wa = run_addr; used_wd = 1'b1;
        if (prev_rd == NIL) begin
          head_d = next_rd;
        end else begin
          next_we = 1'b1; next_wa = prev_rd[IDX_W-1:0]; next_wd = next_rd;
        end
        if (next_rd != NIL) begin
          prev_we = 1'b1; prev_wa = next_rd[IDX_W-1:0]; prev_wd = prev_rd;
        end
        k_d = k_inc;
        if (k_inc == cnt_q) begin
          res_st_d    = ST_OK;
          res_first_d = pos_q[IDX_W-1:0];
          state_d     = S_DONE;
        end else begin
          rd_addr = IDX_W'(pos_q + k_inc);
        end
      end
      S_FR_W: begin
        if (!used_rd) begin
          res_st_d = ST_BAD_REQ;
          state_d  = S_DONE;
        end else begin
          used_we = 1'b1; used_wa = fidx_q; used_wd = 1'b0;
          next_we = 1'b1; next_wa = fidx_q; next_wd = head_q;
          prev_we = 1'b1; prev_wa = fidx_q; prev_wd = NIL;
          res_st_d = ST_OK;
          if (head_q == NIL) begin
            head_d  = {1'b0, fidx_q};
            state_d = S_DONE;
          end else begin
            state_d = S_FR2;
          end
        end
      end
      S_FR2: begin
        prev_we = 1'b1; prev_wa = head_q[IDX_W-1:0]; prev_wd = {1'b0, fidx_q};
        head_d  = {1'b0, fidx_q};
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // a register write rebuilds the list
    if (cfg_we_i) begin
      total_d = cfg_sat;
      k_d     = '0;
      state_d = S_CLR;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      total_q     <= LINK_W'(NUM_FRAMES);
      head_q      <= NIL;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      fn_v_q      <= 1'b0;
      fp_v_q      <= 1'b0;
      fu_v_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      head_q  <= head_d;
      k_q     <= k_d;
      fn_v_q  <= next_we;
      fp_v_q  <= prev_we;
      fu_v_q  <= used_we;
      if (state_q == S_DONE && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    cnt_q       <= cnt_d;
    fidx_q      <= fidx_d;
    res_st_q    <= res_st_d;
    res_first_q <= res_first_d;
    rd_addr_q   <= rd_addr;
    fn_a_q <= next_wa; fn_d_q <= next_wd;
    fp_a_q <= prev_wa; fp_d_q <= prev_wd;
    fu_a_q <= used_wa; fu_d_q <= used_wd;
    if (state_q == S_DONE && (!out_valid_q || m_axis_tready)) begin
      out_st_q    <= res_st_q;
      out_first_q <= res_first_q;
    end
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    next_raw_q <= next_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    prev_raw_q <= prev_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (used_we) used_mem[used_wa] <= used_wd;
    used_raw_q <= used_mem[rd_addr];
  end

  // checks
  `PFA_ASSERT(a_head_range, clk_i, rst_ni, head_q <= NIL, "list head out of range")
  `PFA_ASSERT(a_total_range, clk_i, rst_ni,
    (total_q != '0) && (total_q <= LINK_W'(NUM_FRAMES)), "frame count out of range")
  `PFA_ASSERT(a_free_first_zero, clk_i, rst_ni,
    (out_valid_q && out_st_q != ST_OK) |-> (out_first_q == '0), "failed result has a frame")
  `PFA_ASSERT_ALWAYS(a_no_accept_in_clear, clk_i,
    (state_q == S_CLR) |-> !s_axis_tready, "item accepted during clearing pass")
endmodule
